// ===== rtl/sobel_edge_magnitude_rgb_assert.svh =====
// assertion helpers for the sobel edge block, clocked on clk_i, quiet in reset
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sobel edge: same-cycle check failed");

// next-cycle implication
`define SEM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sobel edge: next-cycle check failed");

`endif

// ===== rtl/sem_pkg.sv =====
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 24;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int ROOT_STEPS = 8;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam logic [10:0] WIDTH_MAX    = 11'(MAX_WIDTH);
  localparam logic [20:0] SAT_LIMIT    = 21'd65280;
  localparam logic [7:0]  MAG_MAX      = 8'd255;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  // input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;   // [row][col]

  typedef struct packed {
    win_t win;
    logic row_end;
    logic frame_end;
  } job_t;

endpackage

// ===== rtl/sem_pix_if.sv =====
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output action, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink (input valid, input action, input in_red, input in_green,
                input in_blue, output ready);
endinterface

interface sem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, output edge_red, output edge_green, output edge_blue,
                  output row_end, output frame_end, input ready);
  modport sink (input valid, input edge_red, input edge_green, input edge_blue,
                input row_end, input frame_end, output ready);
endinterface

// ===== rtl/sem_ram.sv =====
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sem_queue.sv =====
module sem_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sem_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output sem_pkg::job_t job_o,
  output logic          empty_o
);
  import sem_pkg::*;

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/sem_front.sv =====
module sem_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sem_pix_if.sink       pix,
  input  logic [10:0]   frame_width_i,
  input  logic [15:0]   frame_height_i,
  output logic          push_o,
  output sem_pkg::job_t job_o,
  input  logic          full_i
);
  import sem_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_PWR  = 5'b00010,
    F_DRD  = 5'b00100,
    F_DCAP = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e st_q;
  logic [ADDR_W-1:0] col_q, cur_col_q;
  logic [15:0] row_q, cur_row_q;
  logic [10:0] drain_q, d_q;
  logic        pend_q, has_up_q, lc_q;
  logic [1:0]  off_q;
  logic        ok_q, dlast_q;
  pix_t        pix_q;
  win_t        win_q;
  logic        need_win_q, need_edge_q, fl_q;

  logic [10:0] w_eff, wm1, d_new, j_sum;
  logic [15:0] h_eff;
  logic        accept, last_col;
  logic [ADDR_W-1:0] raddr;
  pix_t        up_rd, mid_rd, top_v, mid_v;
  win_t        edge_win;

  always_comb begin
    if (frame_width_i == '0)           w_eff = 11'd1;
    else if (frame_width_i > WIDTH_MAX) w_eff = WIDTH_MAX;
    else                                w_eff = frame_width_i;
    h_eff = (frame_height_i == '0) ? 16'd1 : frame_height_i;
  end
  assign wm1 = w_eff - 11'd1;

  assign pix.ready = (st_q == F_IDLE);
  assign accept    = pix.valid && pix.ready;
  assign last_col  = ({1'b0, col_q} >= wm1);
  assign d_new     = (drain_q >= wm1) ? wm1 : drain_q;
  assign j_sum     = d_q + 11'(off_q);

  // pixel reads its column at accept, drain reads column d-1+off
  assign raddr = (st_q == F_DRD) ? ADDR_W'(j_sum - 11'd1) : col_q;

  assign top_v = (cur_row_q >= 16'd2) ? up_rd : '0;
  assign mid_v = (cur_row_q >= 16'd1) ? mid_rd : '0;

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (st_q == F_PWR),
    .waddr_i (cur_col_q),
    .wdata_i (mid_rd),
    .raddr_i (raddr),
    .rdata_o (up_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (st_q == F_PWR),
    .waddr_i (cur_col_q),
    .wdata_i (pix_q),
    .raddr_i (raddr),
    .rdata_o (mid_rd)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      edge_win[k][0] = win_q[k][1];
      edge_win[k][1] = win_q[k][2];
      edge_win[k][2] = '0;
    end
  end

  assign push_o = (st_q == F_PUSH) && !full_i;
  always_comb begin
    if (need_win_q) job_o = '{win: win_q, row_end: fl_q, frame_end: fl_q};
    else            job_o = '{win: edge_win, row_end: 1'b1, frame_end: 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q     <= {pix.in_red, pix.in_green, pix.in_blue};
      cur_col_q <= col_q;
      cur_row_q <= row_q;
      lc_q      <= last_col;
      d_q       <= d_new;
      dlast_q   <= (d_new >= wm1);
    end
    if (st_q == F_DRD) begin
      ok_q <= (j_sum >= 11'd1) && ((j_sum - 11'd1) < w_eff);
    end
    if (st_q == F_PWR) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= (cur_col_q == '0) ? '0 : win_q[k][1];
        win_q[k][1] <= (cur_col_q == '0) ? '0 : win_q[k][2];
      end
      win_q[0][2] <= top_v;
      win_q[1][2] <= mid_v;
      win_q[2][2] <= pix_q;
    end
    if (st_q == F_DCAP) begin
      win_q[0][off_q] <= (ok_q && has_up_q) ? up_rd : '0;
      win_q[1][off_q] <= ok_q ? mid_rd : '0;
      win_q[2][off_q] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= F_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      drain_q     <= '0;
      pend_q      <= 1'b0;
      has_up_q    <= 1'b0;
      off_q       <= '0;
      need_win_q  <= 1'b0;
      need_edge_q <= 1'b0;
      fl_q        <= 1'b0;
    end else begin
      unique case (st_q)
        F_IDLE: begin
          if (accept && pix.action == ACT_PIXEL && !pend_q) begin
            st_q <= F_PWR;
            if (last_col) begin
              col_q <= '0;
              if (row_q >= h_eff - 16'd1) begin
                row_q    <= '0;
                pend_q   <= 1'b1;
                drain_q  <= '0;
                has_up_q <= (row_q >= 16'd1);
              end else begin
                row_q <= row_q + 16'd1;
              end
            end else begin
              col_q <= col_q + 1'b1;
            end
          end else if (accept && pix.action == ACT_DRAIN && pend_q) begin
            st_q  <= F_DRD;
            off_q <= '0;
            if (d_new >= wm1) begin
              pend_q  <= 1'b0;
              drain_q <= '0;
            end else begin
              drain_q <= d_new + 11'd1;
            end
          end
        end
        F_PWR: begin
          need_win_q  <= (cur_row_q >= 16'd1) && (cur_col_q != '0);
          need_edge_q <= (cur_row_q >= 16'd1) && lc_q;
          fl_q        <= 1'b0;
          st_q        <= (cur_row_q >= 16'd1 && (cur_col_q != '0 || lc_q)) ? F_PUSH : F_IDLE;
        end
        F_DRD: begin
          st_q <= F_DCAP;
        end
        F_DCAP: begin
          if (off_q == 2'd2) begin
            need_win_q  <= 1'b1;
            need_edge_q <= 1'b0;
            fl_q        <= dlast_q;
            st_q        <= F_PUSH;
          end else begin
            off_q <= off_q + 2'd1;
            st_q  <= F_DRD;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            if (need_win_q) begin
              need_win_q <= 1'b0;
              if (!need_edge_q) st_q <= F_IDLE;
            end else begin
              need_edge_q <= 1'b0;
              st_q        <= F_IDLE;
            end
          end
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sem_back.sv =====
module sem_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  sem_pkg::job_t job_i,
  output logic          pop_o,
  sem_res_if.source     res
);
  import sem_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SQ   = 4'b0010,
    B_ROOT = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_e;

  bstate_e st_q;
  logic signed [10:0] gx_q [3], gy_q [3];
  logic [15:0] rad_q [3];
  logic        sat_q [3];
  logic [8:0]  rem_q [3];
  logic [7:0]  root_q [3];
  logic [7:0]  mag_q [3];
  logic [2:0]  step_q;
  logic        re_q, fe_q;

  logic signed [10:0] gx_d [3], gy_d [3];
  logic [20:0] ssum [3];
  logic [10:0] rem_sh [3], trial [3];
  logic [8:0]  rem_n [3];
  logic [7:0]  root_n [3];

  function automatic logic [10:0] chan(input pix_t p, input int ch);
    return {3'b000, p[8*(2-ch) +: 8]};
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      gx_d[ch] = 11'($signed({1'b0, chan(job_i.win[0][2], ch) + (chan(job_i.win[1][2], ch) << 1)
                 + chan(job_i.win[2][2], ch)})
                 - $signed({1'b0, chan(job_i.win[0][0], ch) + (chan(job_i.win[1][0], ch) << 1)
                 + chan(job_i.win[2][0], ch)}));
      gy_d[ch] = 11'($signed({1'b0, chan(job_i.win[2][0], ch) + (chan(job_i.win[2][1], ch) << 1)
                 + chan(job_i.win[2][2], ch)})
                 - $signed({1'b0, chan(job_i.win[0][0], ch) + (chan(job_i.win[0][1], ch) << 1)
                 + chan(job_i.win[0][2], ch)}));
      ssum[ch]   = 21'($unsigned(22'(gx_q[ch]) * 22'(gx_q[ch])))
                 + 21'($unsigned(22'(gy_q[ch]) * 22'(gy_q[ch])));
      // one digit of the restoring square root
      rem_sh[ch] = {rem_q[ch], rad_q[ch][15:14]};
      trial[ch]  = {1'b0, root_q[ch], 2'b01};
      if (rem_sh[ch] >= trial[ch]) begin
        rem_n[ch]  = 9'(rem_sh[ch] - trial[ch]);
        root_n[ch] = {root_q[ch][6:0], 1'b1};
      end else begin
        rem_n[ch]  = rem_sh[ch][8:0];
        root_n[ch] = {root_q[ch][6:0], 1'b0};
      end
    end
  end

  assign pop_o      = (st_q == B_IDLE) && !empty_i;
  assign res.valid  = (st_q == B_OUT);
  assign res.edge_red   = mag_q[0];
  assign res.edge_green = mag_q[1];
  assign res.edge_blue  = mag_q[2];
  assign res.row_end    = re_q;
  assign res.frame_end  = fe_q;

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (pop_o) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
      if (st_q == B_SQ) begin
        sat_q[ch]  <= (ssum[ch] > SAT_LIMIT);
        rad_q[ch]  <= ssum[ch][15:0];
        rem_q[ch]  <= '0;
        root_q[ch] <= '0;
      end
      if (st_q == B_ROOT) begin
        rad_q[ch]  <= {rad_q[ch][13:0], 2'b00};
        rem_q[ch]  <= rem_n[ch];
        root_q[ch] <= root_n[ch];
        if (step_q == 3'(ROOT_STEPS - 1)) begin
          // round up when the remainder passes the root
          mag_q[ch] <= sat_q[ch] ? MAG_MAX
                     : root_n[ch] + 8'({7'd0, ({8'd0, rem_n[ch]} > {9'd0, root_n[ch]})});
        end
      end
    end
    if (pop_o) begin
      re_q <= job_i.row_end;
      fe_q <= job_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      step_q <= '0;
    end else begin
      unique case (st_q)
        B_IDLE: if (!empty_i) st_q <= B_SQ;
        B_SQ: begin
          step_q <= '0;
          st_q   <= B_ROOT;
        end
        B_ROOT: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'(ROOT_STEPS - 1)) st_q <= B_OUT;
        end
        B_OUT: if (res.ready) st_q <= B_IDLE;
        default: st_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// a pixel transaction holds the front end for a line read, then an update, plus
//   a push per window it hands on; a drain transaction for three column reads and a push
// a window entering an idle back end is popped, squared and run through 8 root digits to a result
// the bit-serial root back end pops the next window only after its result is taken
// reset: asynchronous active low; counters, queue and handshakes clear, widths go to
//   640 x 480; line stores keep their contents and need no clearing pass
module sobel_edge_magnitude_rgb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sem_pix_if.sink     pix_i,
  sem_res_if.source   res_o
);
  import sem_pkg::*;

  // frame geometry registers
  logic [10:0] frame_width_q;
  logic [15:0] frame_height_q;

  // queue between the front end (windows) and the back end (magnitude)
  logic q_push, q_pop, q_full, q_empty;
  job_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      // unknown indexes are dropped
      if (cfg_idx_i == CFG_FRAME_WIDTH)  frame_width_q  <= cfg_data_i[10:0];
      if (cfg_idx_i == CFG_FRAME_HEIGHT) frame_height_q <= cfg_data_i;
    end
  end

  // front end: counters, line stores, window build and drain sequencing
  sem_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix            (pix_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .push_o         (q_push),
    .job_o          (q_in),
    .full_i         (q_full)
  );

  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_out),
    .empty_o (q_empty)
  );

  // back end: sobel gradients, squared sum and rounded root with clamp
  sem_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .job_i   (q_out),
    .pop_o   (q_pop),
    .res     (res_o)
  );

  `include "sobel_edge_magnitude_rgb_assert.svh"

  // the front end never writes into a full queue, the back end never reads an empty one
  `SEM_ASSERT_IMP(a_push_room, q_push, !q_full)
  `SEM_ASSERT_IMP(a_pop_data, q_pop, !q_empty)
  // only the last drain result closes a frame, and it also closes its row
  `SEM_ASSERT_IMP(a_frame_row, res_o.valid && res_o.frame_end, res_o.row_end)
  // a result transaction stays offered until it is taken
  `SEM_ASSERT_NXT(a_res_hold, res_o.valid && !res_o.ready, res_o.valid)

endmodule
